// ===== hw/rtl/kda_pkg.sv =====
// Shared constants and codes for the keypad debounce and auto-repeat block.
package kda_pkg;

    localparam int KDA_KEY_BITS   = 16;
    localparam int OPCODE_W       = 3;
    localparam int SWITCH_PINS_W  = 2;
    localparam int AUX_W          = 4;
    localparam int SWITCH_W       = SWITCH_PINS_W + AUX_W;
    localparam int HELD_W         = 8;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [HELD_W-1:0] HELD_MAX         = '1;
    localparam logic [7:0]        REPEAT_DELAY_RST  = 8'd20;
    localparam logic [7:0]        REPEAT_PERIOD_RST = 8'd4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SCAN          = 3'd0,
        OP_TAKE_PRESS    = 3'd1,
        OP_TAKE_RELEASE  = 3'd2,
        OP_CLEAR_PRESS   = 3'd3,
        OP_TEST_STATE    = 3'd4,
        OP_FLUSH         = 3'd5,
        OP_STOP_COUNT    = 3'd6
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REPEAT_DELAY   = 2'd0,
        CFG_REPEAT_PERIOD  = 2'd1,
        CFG_NO_REPEAT_KEYS = 2'd2
    } cfg_index_t;

endpackage

// ===== hw/rtl/kda_engine.sv =====
// Key state, configuration registers and the single-pass update for one transaction.
module kda_engine
    import kda_pkg::*;
#(
    parameter int KEY_BITS = KDA_KEY_BITS,
    localparam int CFG_W = (KEY_BITS > 8) ? KEY_BITS : 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     fire,
    input  logic [OPCODE_W-1:0]      opcode,
    input  logic [KEY_BITS-1:0]      matrix_raw,
    input  logic [SWITCH_PINS_W-1:0] switch_pins,
    input  logic [AUX_W-1:0]         aux_pins,
    input  logic [KEY_BITS-1:0]      key_select,
    output logic                     answer,
    output logic [KEY_BITS-1:0]      debounced_keys,
    output logic [SWITCH_W-1:0]      switch_state,
    output logic                     key_feedback
);

    localparam logic [KEY_BITS-1:0] ALL_KEYS = '1;

    logic [7:0]          repeat_delay_reg;
    logic [7:0]          repeat_period_reg;
    logic [KEY_BITS-1:0] no_repeat_keys_reg;

    logic [KEY_BITS-1:0] pending_press_reg,   pending_press_next;
    logic [KEY_BITS-1:0] pending_release_reg, pending_release_next;
    logic [KEY_BITS-1:0] last_sample_reg,     last_sample_next;
    logic [KEY_BITS-1:0] stable_keys_reg,     stable_keys_next;
    logic [HELD_W-1:0]   held_scans_reg,      held_scans_next;
    logic [AUX_W-1:0]    aux_latched_reg,     aux_latched_next;
    logic [SWITCH_W-1:0] switch_last_reg,     switch_last_next;
    logic [SWITCH_W-1:0] switch_stable_reg,   switch_stable_next;

    logic [HELD_W-1:0]   held_tmp;
    logic [KEY_BITS-1:0] press_rep;
    logic [SWITCH_W-1:0] sw;
    logic                answer_c;
    logic                feedback_c;

    always_comb begin
        pending_press_next   = pending_press_reg;
        pending_release_next = pending_release_reg;
        last_sample_next     = last_sample_reg;
        stable_keys_next     = stable_keys_reg;
        held_scans_next      = held_scans_reg;
        aux_latched_next     = aux_latched_reg;
        switch_last_next     = switch_last_reg;
        switch_stable_next   = switch_stable_reg;
        answer_c             = 1'b0;
        feedback_c           = 1'b0;
        held_tmp             = held_scans_reg;
        press_rep            = pending_press_reg & (matrix_raw | no_repeat_keys_reg);
        sw                   = '0;

        case (opcode)
            OP_SCAN: begin
                if (matrix_raw == ALL_KEYS) begin
                    aux_latched_next = ~aux_pins;
                end
                if (matrix_raw == last_sample_reg) begin
                    stable_keys_next = matrix_raw;
                    if (matrix_raw != ALL_KEYS) begin
                        if (held_scans_reg == '0) begin
                            feedback_c         = 1'b1;
                            pending_press_next = pending_press_reg & matrix_raw;
                        end else if (held_scans_reg >= repeat_delay_reg) begin
                            pending_release_next = pending_release_reg & matrix_raw;
                            pending_press_next   = press_rep;
                            held_tmp = (repeat_delay_reg > repeat_period_reg)
                                     ? repeat_delay_reg - repeat_period_reg : '0;
                            feedback_c = (press_rep != pending_press_reg);
                        end
                        held_scans_next = (held_tmp != HELD_MAX) ? held_tmp + 1'b1 : held_tmp;
                    end else begin
                        pending_release_next = ALL_KEYS;
                        held_scans_next      = '0;
                    end
                end else begin
                    last_sample_next = matrix_raw;
                end
                sw = {aux_latched_next, switch_pins};
                if (sw == switch_last_reg) begin
                    switch_stable_next = sw;
                end else begin
                    switch_last_next = sw;
                end
            end
            OP_TAKE_PRESS: begin
                if ((pending_press_reg & key_select) == '0) begin
                    pending_press_next = pending_press_reg | key_select;
                    answer_c           = 1'b1;
                end
            end
            OP_TAKE_RELEASE: begin
                if ((pending_release_reg & key_select) == '0) begin
                    pending_release_next = pending_release_reg | key_select;
                    answer_c             = 1'b1;
                end
            end
            OP_CLEAR_PRESS: begin
                pending_press_next = pending_press_reg | key_select;
            end
            OP_TEST_STATE: begin
                answer_c = ((stable_keys_reg & key_select) == '0);
            end
            OP_FLUSH: begin
                pending_press_next   = ALL_KEYS;
                pending_release_next = ALL_KEYS;
                last_sample_next     = ALL_KEYS;
                stable_keys_next     = ALL_KEYS;
                held_scans_next      = '0;
            end
            OP_STOP_COUNT: begin
                held_scans_next = HELD_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign answer         = answer_c;
    assign key_feedback   = feedback_c;
    assign debounced_keys = stable_keys_next;
    assign switch_state   = switch_stable_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_delay_reg    <= REPEAT_DELAY_RST;
            repeat_period_reg   <= REPEAT_PERIOD_RST;
            no_repeat_keys_reg  <= '0;
            pending_press_reg   <= ALL_KEYS;
            pending_release_reg <= ALL_KEYS;
            last_sample_reg     <= ALL_KEYS;
            stable_keys_reg     <= ALL_KEYS;
            held_scans_reg      <= '0;
            aux_latched_reg     <= '0;
            switch_last_reg     <= '0;
            switch_stable_reg   <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_REPEAT_DELAY:   repeat_delay_reg   <= cfg_wdata[7:0];
                    CFG_REPEAT_PERIOD:  repeat_period_reg  <= cfg_wdata[7:0];
                    CFG_NO_REPEAT_KEYS: no_repeat_keys_reg <= cfg_wdata[KEY_BITS-1:0];
                    default: begin
                    end
                endcase
            end
            if (fire) begin
                pending_press_reg   <= pending_press_next;
                pending_release_reg <= pending_release_next;
                last_sample_reg     <= last_sample_next;
                stable_keys_reg     <= stable_keys_next;
                held_scans_reg      <= held_scans_next;
                aux_latched_reg     <= aux_latched_next;
                switch_last_reg     <= switch_last_next;
                switch_stable_reg   <= switch_stable_next;
            end
        end
    end

endmodule

// ===== hw/rtl/keypad_debounce_autorepeat_core.sv =====
// Top level: input register, key engine and result register of the keypad block.
// An accepted input transaction is held in the input register; its result is then registered onto m_tdata.
// Throughput: one transaction per cycle unless m_tready stalls; the state update is one combinational pass.
// A waiting result stalls the input once the input register holds a transaction.
// Reset (aresetn low, synchronous) empties both registers, restores the
// configuration defaults and sets all key flags to released.
module keypad_debounce_autorepeat_core
    import kda_pkg::*;
#(
    parameter int KEY_BITS = KDA_KEY_BITS,
    localparam int CFG_W  = (KEY_BITS > 8) ? KEY_BITS : 8,
    localparam int IN_BITS  = OPCODE_W + KEY_BITS + SWITCH_PINS_W + AUX_W + KEY_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 1 + KEY_BITS + SWITCH_W + 1,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode, matrix_raw, switch_pins, aux_pins, key_select (lowest first)
    input  logic [IN_W-1:0]        s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // answer, debounced_keys, switch_state, key_feedback (lowest first)
    output logic [OUT_W-1:0]       m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int MR_LO = OPCODE_W;
    localparam int SP_LO = MR_LO + KEY_BITS;
    localparam int AX_LO = SP_LO + SWITCH_PINS_W;
    localparam int KS_LO = AX_LO + AUX_W;

    logic                 in_valid_reg;
    logic [IN_BITS-1:0]   in_data_reg;
    logic                 out_valid_reg;
    logic [OUT_BITS-1:0]  out_data_reg;
    logic                 advance;

    logic                 answer;
    logic [KEY_BITS-1:0]  debounced_keys;
    logic [SWITCH_W-1:0]  switch_state;
    logic                 key_feedback;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= {key_feedback, switch_state, debounced_keys, answer};
        end
    end

    kda_engine #(
        .KEY_BITS (KEY_BITS)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .fire           (advance),
        .opcode         (in_data_reg[OPCODE_W-1:0]),
        .matrix_raw     (in_data_reg[SP_LO-1:MR_LO]),
        .switch_pins    (in_data_reg[AX_LO-1:SP_LO]),
        .aux_pins       (in_data_reg[KS_LO-1:AX_LO]),
        .key_select     (in_data_reg[IN_BITS-1:KS_LO]),
        .answer         (answer),
        .debounced_keys (debounced_keys),
        .switch_state   (switch_state),
        .key_feedback   (key_feedback)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule
